>>> sv/graph_edge_table_engine_macros.svh
// ----------------------------------------------------------------------------
// graph edge table engine assertion macros
// shared property forms for the engine's checks
// ----------------------------------------------------------------------------
`ifndef GRAPH_EDGE_TABLE_ENGINE_MACROS_SVH
`define GRAPH_EDGE_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define GETE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define GETE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/gete_pkg.sv
// ----------------------------------------------------------------------------
// gete_pkg
// field widths, operation and status codes of the graph edge table engine
// ----------------------------------------------------------------------------
package gete_pkg;

  localparam int unsigned DefaultEdges      = 64;
  localparam int unsigned DefaultVertexBits = 16;

  localparam int unsigned OpW   = 2;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned VtxW  = 16;
  localparam int unsigned VcntW = 8;
  localparam int unsigned EcntW = 7;
  localparam int unsigned StatW = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_NBR = 2'd2,
    OP_CNT = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NONE      = 2'd3
  } status_e;

endpackage

>>> sv/gete_ram.sv
// ----------------------------------------------------------------------------
// gete_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module gete_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/graph_edge_table_engine.sv
// ----------------------------------------------------------------------------
// graph_edge_table_engine
// undirected edge list with add, delete, neighbour listing and distinct
// vertex count, worked through one slot memory by a small sequencer
//
//   channel   direction  handshake                 payload
//   command   in         start && !busy            op_i, edge_index_i,
//                                                  first_vertex_i, second_vertex_i
//   result    out        result_valid_o (1 cycle)  neighbor_o, vertex_count_o,
//                                                  edge_count_o, status_o, last_o
//
// an add is answered at once; a delete reads its slot before clearing it (an
// index past the filled slots is refused without a read); a neighbour listing
// scans every filled slot; a count compares each live slot against every
// earlier slot through the single read port
// busy is high while a delete, listing or count runs, until its final result;
// an add or an out-of-range delete never raises it; results cannot be stalled;
// reset empties the table at once
`include "graph_edge_table_engine_macros.svh"

module graph_edge_table_engine #(
  parameter int unsigned EDGES       = gete_pkg::DefaultEdges,
  parameter int unsigned VERTEX_BITS = gete_pkg::DefaultVertexBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [gete_pkg::OpW-1:0]    op_i,
  input  logic [gete_pkg::IdxW-1:0]   edge_index_i,
  input  logic [gete_pkg::VtxW-1:0]   first_vertex_i,
  input  logic [gete_pkg::VtxW-1:0]   second_vertex_i,
  output logic                        result_valid_o,
  output logic [gete_pkg::VtxW-1:0]   neighbor_o,
  output logic [gete_pkg::VcntW-1:0]  vertex_count_o,
  output logic [gete_pkg::EcntW-1:0]  edge_count_o,
  output logic [gete_pkg::StatW-1:0]  status_o,
  output logic                        last_o
);
  import gete_pkg::*;

  localparam int unsigned EW = $clog2(EDGES);
  localparam int unsigned CW = $clog2(EDGES + 1);
  localparam int unsigned NW = $clog2(2 * EDGES + 1);
  localparam int unsigned IW = (CW > IdxW) ? CW : IdxW;
  localparam int unsigned RW = 2 * VERTEX_BITS + 1;

  typedef logic [VERTEX_BITS-1:0] vtx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_CHK,
    S_NB,
    S_CNT_OUT,
    S_CNT_HDR,
    S_CNT_IN
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   filled_q, filled_d;
  logic [CW-1:0]   live_q, live_d;
  logic [CW-1:0]   rd_q, rd_d;
  logic            chk_q, chk_d;
  logic            pend_q, pend_d;
  vtx_t            pend_nb_q, pend_nb_d;
  logic [CW-1:0]   out_q, out_d;
  logic [NW-1:0]   n_q, n_d;
  vtx_t            u_q, u_d;
  vtx_t            ca_q, ca_d;
  vtx_t            cb_q, cb_d;
  logic            dup_a_q, dup_a_d;
  logic            dup_b_q, dup_b_d;
  logic [EW-1:0]   del_addr_q, del_addr_d;
  logic            res_valid_q, res_valid_d;
  vtx_t            nb_q, nb_d;
  logic [VcntW-1:0] vcount_q, vcount_d;
  logic [EcntW-1:0] ecount_q, ecount_d;
  status_e         status_q, status_d;
  logic            last_q, last_d;

  logic            ram_we;
  logic [EW-1:0]   ram_waddr;
  logic [RW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_raddr;
  logic [RW-1:0]   ram_rdata;

  logic            ent_valid;
  vtx_t            ent_a, ent_b;
  vtx_t            key;
  logic            a_is_key, b_is_key, a_is_cb, b_is_cb;
  vtx_t            u_in, v_in;
  logic [IW-1:0]   idx_ext, fill_ext;

  gete_ram #(
    .Width(RW),
    .Depth(EDGES)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ent_valid = ram_rdata[RW-1];
  assign ent_a     = ram_rdata[2*VERTEX_BITS-1:VERTEX_BITS];
  assign ent_b     = ram_rdata[VERTEX_BITS-1:0];

  // shared compare unit
  assign key      = (state_q == S_NB) ? u_q : ca_q;
  assign a_is_key = (ent_a == key);
  assign b_is_key = (ent_b == key);
  assign a_is_cb  = (ent_a == cb_q);
  assign b_is_cb  = (ent_b == cb_q);

  assign u_in     = VERTEX_BITS'(first_vertex_i);
  assign v_in     = VERTEX_BITS'(second_vertex_i);
  assign idx_ext  = IW'(edge_index_i);
  assign fill_ext = IW'(filled_q);

  always_comb begin
    state_d     = state_q;
    filled_d    = filled_q;
    live_d      = live_q;
    rd_d        = rd_q;
    chk_d       = 1'b0;
    pend_d      = pend_q;
    pend_nb_d   = pend_nb_q;
    out_d       = out_q;
    n_d         = n_q;
    u_d         = u_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    dup_a_d     = dup_a_q;
    dup_b_d     = dup_b_q;
    del_addr_d  = del_addr_q;
    res_valid_d = 1'b0;
    nb_d        = '0;
    vcount_d    = '0;
    status_d    = ST_OK;
    last_d      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = filled_q[EW-1:0];
    ram_wdata   = {1'b1, u_in, v_in};
    ram_raddr   = rd_q[EW-1:0];

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = idx_ext[EW-1:0];
        if (start) begin
          unique case (op_e'(op_i))
            OP_ADD: begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
              if (filled_q == CW'(EDGES)) begin
                status_d = ST_FULL;
              end else begin
                ram_we   = 1'b1;
                filled_d = filled_q + 1'b1;
                live_d   = live_q + 1'b1;
              end
            end
            OP_DEL: begin
              if (idx_ext >= fill_ext) begin
                res_valid_d = 1'b1;
                last_d      = 1'b1;
                status_d    = ST_BAD_INDEX;
              end else begin
                del_addr_d = idx_ext[EW-1:0];
                state_d    = S_DEL_CHK;
              end
            end
            OP_NBR: begin
              u_d     = u_in;
              rd_d    = '0;
              pend_d  = 1'b0;
              state_d = S_NB;
            end
            OP_CNT: begin
              out_d   = '0;
              n_d     = '0;
              state_d = S_CNT_OUT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_DEL_CHK: begin
        res_valid_d = 1'b1;
        last_d      = 1'b1;
        if (!ent_valid) begin
          status_d = ST_BAD_INDEX;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = del_addr_q;
          ram_wdata = {1'b0, ent_a, ent_b};
          live_d    = live_q - 1'b1;
        end
        state_d = S_IDLE;
      end

      S_NB: begin
        if (rd_q != filled_q) begin
          rd_d  = rd_q + 1'b1;
          chk_d = 1'b1;
        end
        if (chk_q && ent_valid && (a_is_key || b_is_key)) begin
          // hold one match back so the final one can carry last
          if (pend_q) begin
            res_valid_d = 1'b1;
            nb_d        = pend_nb_q;
          end
          pend_d    = 1'b1;
          pend_nb_d = a_is_key ? ent_b : ent_a;
        end
        if (rd_q == filled_q && !chk_q) begin
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          if (pend_q) begin
            nb_d = pend_nb_q;
          end else begin
            status_d = ST_NONE;
          end
          state_d = S_IDLE;
        end
      end

      S_CNT_OUT: begin
        ram_raddr = out_q[EW-1:0];
        if (out_q == filled_q) begin
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          vcount_d    = (32'(n_q) > 32'd255) ? 8'hFF : 8'(n_q);
          state_d     = S_IDLE;
        end else begin
          state_d = S_CNT_HDR;
        end
      end

      S_CNT_HDR: begin
        if (!ent_valid) begin
          out_d   = out_q + 1'b1;
          state_d = S_CNT_OUT;
        end else begin
          ca_d    = ent_a;
          cb_d    = ent_b;
          dup_a_d = 1'b0;
          dup_b_d = (ent_a == ent_b);
          rd_d    = '0;
          state_d = S_CNT_IN;
        end
      end

      S_CNT_IN: begin
        if (rd_q != out_q) begin
          rd_d  = rd_q + 1'b1;
          chk_d = 1'b1;
        end
        if (chk_q && ent_valid) begin
          dup_a_d = dup_a_q | a_is_key | b_is_key;
          dup_b_d = dup_b_q | a_is_cb | b_is_cb;
        end
        if (rd_q == out_q && !chk_q) begin
          n_d     = n_q + NW'(!dup_a_q) + NW'(!dup_b_q);
          out_d   = out_q + 1'b1;
          state_d = S_CNT_OUT;
        end
      end

      default: state_d = S_IDLE;
    endcase

    ecount_d = (32'(live_d) > 32'd127) ? 7'h7F : 7'(live_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filled_q    <= '0;
      live_q      <= '0;
      rd_q        <= '0;
      chk_q       <= 1'b0;
      pend_q      <= 1'b0;
      pend_nb_q   <= '0;
      out_q       <= '0;
      n_q         <= '0;
      u_q         <= '0;
      ca_q        <= '0;
      cb_q        <= '0;
      dup_a_q     <= 1'b0;
      dup_b_q     <= 1'b0;
      del_addr_q  <= '0;
      res_valid_q <= 1'b0;
      nb_q        <= '0;
      vcount_q    <= '0;
      ecount_q    <= '0;
      status_q    <= ST_OK;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      live_q      <= live_d;
      rd_q        <= rd_d;
      chk_q       <= chk_d;
      pend_q      <= pend_d;
      pend_nb_q   <= pend_nb_d;
      out_q       <= out_d;
      n_q         <= n_d;
      u_q         <= u_d;
      ca_q        <= ca_d;
      cb_q        <= cb_d;
      dup_a_q     <= dup_a_d;
      dup_b_q     <= dup_b_d;
      del_addr_q  <= del_addr_d;
      res_valid_q <= res_valid_d;
      nb_q        <= nb_d;
      vcount_q    <= vcount_d;
      ecount_q    <= ecount_d;
      status_q    <= status_d;
      last_q      <= last_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign neighbor_o     = VtxW'(nb_q);
  assign vertex_count_o = vcount_q;
  assign edge_count_o   = ecount_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

  // live edges never outnumber used slots
  `GETE_ASSERT_NOW(a_live_le_filled, clk_i, rst_ni, 1'b1, live_q <= filled_q, "live count above filled count")
  `GETE_ASSERT_NOW(a_filled_le_depth, clk_i, rst_ni, 1'b1, filled_q <= CW'(EDGES), "filled count beyond table depth")
  `GETE_ASSERT_NEXT(a_filled_monotonic, clk_i, rst_ni, 1'b1, filled_q >= $past(filled_q), "slots reused")
  `GETE_ASSERT_NOW(a_mid_beat_busy, clk_i, rst_ni, result_valid_o && !last_o, busy, "non-final beat while idle")
  `GETE_ASSERT_NOW(a_last_beat_idle, clk_i, rst_ni, result_valid_o && last_o, !busy, "final beat while still busy")
  `GETE_ASSERT_NEXT(a_start_acts, clk_i, rst_ni, start && !busy, busy || result_valid_o, "command dropped")

endmodule

>>> test/graph_edge_table_engine_tb.sv
// ----------------------------------------------------------------------------
// graph_edge_table_engine_tb
// drives add, delete, neighbour and count commands with random idle gaps and
// checks every result beat against a model of the edge table or a row's answer
// ----------------------------------------------------------------------------
module graph_edge_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gete_pkg::*;

  localparam int unsigned Edges = DefaultEdges;
  localparam int unsigned DirN  = 19;

  typedef struct packed {
    logic [VtxW-1:0]  neighbor;
    logic [VcntW-1:0] vertex_count;
    logic [EcntW-1:0] edge_count;
    status_e          status;
    logic             last;
  } answer_t;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  idx;
    logic [VtxW-1:0]  u;
    logic [VtxW-1:0]  v;
    bit               typed;
    status_e          st;
    logic [EcntW-1:0] ec;
    logic [VcntW-1:0] vc;
  } stim_row_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             start           = 1'b0;
  logic [OpW-1:0]   op_i            = '0;
  logic [IdxW-1:0]  edge_index_i    = '0;
  logic [VtxW-1:0]  first_vertex_i  = '0;
  logic [VtxW-1:0]  second_vertex_i = '0;
  logic             busy;
  logic             result_valid_o;
  logic [VtxW-1:0]  neighbor_o;
  logic [VcntW-1:0] vertex_count_o;
  logic [EcntW-1:0] edge_count_o;
  logic [StatW-1:0] status_o;
  logic             last_o;

  answer_t     awaited_answers[$];
  int unsigned mismatches = 0;

  logic [VtxW-1:0] slot_first  [Edges];
  logic [VtxW-1:0] slot_second [Edges];
  bit              slot_live   [Edges];
  int unsigned     slots_used = 0;
  int unsigned     live_count = 0;

  // op, index, first, second, typed, status, edge count, vertex count
  stim_row_t directed_rows [DirN] = '{
    '{OP_CNT, 6'd0,  16'h0000, 16'h0000, 1'b1, ST_OK,        7'd0, 8'd0},
    '{OP_NBR, 6'd0,  16'h0000, 16'h0000, 1'b1, ST_NONE,      7'd0, 8'd0},
    '{OP_DEL, 6'd0,  16'h0000, 16'h0000, 1'b1, ST_BAD_INDEX, 7'd0, 8'd0},
    '{OP_DEL, 6'd63, 16'hffff, 16'hffff, 1'b1, ST_BAD_INDEX, 7'd0, 8'd0},
    '{OP_ADD, 6'd63, 16'h0000, 16'hffff, 1'b1, ST_OK,        7'd1, 8'd0},
    '{OP_ADD, 6'd0,  16'hffff, 16'hffff, 1'b1, ST_OK,        7'd2, 8'd0},
    '{OP_ADD, 6'd0,  16'h1234, 16'h0000, 1'b1, ST_OK,        7'd3, 8'd0},
    '{OP_ADD, 6'd0,  16'h0005, 16'h0005, 1'b1, ST_OK,        7'd4, 8'd0},
    '{OP_NBR, 6'd0,  16'h0000, 16'h0000, 1'b0, ST_OK,        7'd0, 8'd0},
    '{OP_NBR, 6'd0,  16'hffff, 16'h0000, 1'b0, ST_OK,        7'd0, 8'd0},
    '{OP_NBR, 6'd0,  16'h0005, 16'h0000, 1'b0, ST_OK,        7'd0, 8'd0},
    '{OP_CNT, 6'd0,  16'h0000, 16'h0000, 1'b0, ST_OK,        7'd0, 8'd0},
    '{OP_DEL, 6'd1,  16'h0000, 16'h0000, 1'b1, ST_OK,        7'd3, 8'd0},
    '{OP_DEL, 6'd1,  16'h0000, 16'h0000, 1'b1, ST_BAD_INDEX, 7'd3, 8'd0},
    '{OP_DEL, 6'd4,  16'h0000, 16'h0000, 1'b1, ST_BAD_INDEX, 7'd3, 8'd0},
    '{OP_NBR, 6'd0,  16'hffff, 16'h0000, 1'b0, ST_OK,        7'd0, 8'd0},
    '{OP_NBR, 6'd0,  16'h1234, 16'h0000, 1'b0, ST_OK,        7'd0, 8'd0},
    '{OP_NBR, 6'd0,  16'h0007, 16'h0000, 1'b1, ST_NONE,      7'd3, 8'd0},
    '{OP_CNT, 6'd0,  16'h0000, 16'h0000, 1'b0, ST_OK,        7'd0, 8'd0}
  };

  graph_edge_table_engine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .edge_index_i    (edge_index_i),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .result_valid_o  (result_valid_o),
    .neighbor_o      (neighbor_o),
    .vertex_count_o  (vertex_count_o),
    .edge_count_o    (edge_count_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  function automatic answer_t make_answer(input logic [VtxW-1:0] nb, input int unsigned vc,
                                          input status_e st, input logic last);
    answer_t a;
    a.neighbor     = nb;
    a.vertex_count = (vc > 255) ? 8'd255 : vc[VcntW-1:0];
    a.edge_count   = (live_count > 127) ? 7'd127 : live_count[EcntW-1:0];
    a.status       = st;
    a.last         = last;
    return a;
  endfunction

  // works out the result beats of one command and updates the table copy
  task automatic edge_table_answer(input op_e op, input logic [IdxW-1:0] idx,
                                   input logic [VtxW-1:0] u, input logic [VtxW-1:0] v);
    int unsigned     hits;
    logic [VtxW-1:0] distinct[$];
    logic [VtxW-1:0] x;
    bit              known;
    hits = 0;
    case (op)
      OP_ADD: begin
        if (slots_used >= Edges) begin
          awaited_answers.push_back(make_answer('0, 0, ST_FULL, 1'b1));
        end else begin
          slot_first[slots_used]  = u;
          slot_second[slots_used] = v;
          slot_live[slots_used]   = 1'b1;
          slots_used++;
          live_count++;
          awaited_answers.push_back(make_answer('0, 0, ST_OK, 1'b1));
        end
      end
      OP_DEL: begin
        if (idx >= slots_used || !slot_live[idx]) begin
          awaited_answers.push_back(make_answer('0, 0, ST_BAD_INDEX, 1'b1));
        end else begin
          slot_live[idx] = 1'b0;
          live_count--;
          awaited_answers.push_back(make_answer('0, 0, ST_OK, 1'b1));
        end
      end
      OP_NBR: begin
        for (int i = 0; i < slots_used; i++) begin
          if (slot_live[i]) begin
            if (slot_first[i] == u) begin
              awaited_answers.push_back(make_answer(slot_second[i], 0, ST_OK, 1'b0));
              hits++;
            end else if (slot_second[i] == u) begin
              awaited_answers.push_back(make_answer(slot_first[i], 0, ST_OK, 1'b0));
              hits++;
            end
          end
        end
        if (hits == 0) begin
          awaited_answers.push_back(make_answer('0, 0, ST_NONE, 1'b1));
        end else begin
          awaited_answers[awaited_answers.size()-1].last = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < slots_used; i++) begin
          if (slot_live[i]) begin
            for (int e = 0; e < 2; e++) begin
              x = (e == 0) ? slot_first[i] : slot_second[i];
              known = 1'b0;
              foreach (distinct[j]) begin
                if (distinct[j] == x) known = 1'b1;
              end
              if (!known) distinct.push_back(x);
            end
          end
        end
        awaited_answers.push_back(make_answer('0, distinct.size(), ST_OK, 1'b1));
      end
    endcase
  endtask

  task automatic send_command(input op_e op, input logic [IdxW-1:0] idx,
                              input logic [VtxW-1:0] u, input logic [VtxW-1:0] v,
                              input bit quiet);
    while (!quiet && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    op_i            <= op;
    edge_index_i    <= idx;
    first_vertex_i  <= u;
    second_vertex_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    edge_table_answer(op, idx, u, v);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VtxW-1:0] pick_vertex();
    logic [VtxW-1:0] pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                  16'h00a5, 16'h7fff, 16'h8000, 16'hffff};
    if ($urandom_range(99) < 70) return pool[$urandom_range(7)];
    return VtxW'($urandom_range(16'hffff));
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && result_valid_o) begin
      if (awaited_answers.size() == 0) begin
        report($sformatf("result beat with nothing awaited, neighbor %h status %0d",
                         neighbor_o, status_o));
      end else begin
        want = awaited_answers.pop_front();
        if (neighbor_o !== want.neighbor)
          report($sformatf("neighbor %h, expected %h", neighbor_o, want.neighbor));
        if (vertex_count_o !== want.vertex_count)
          report($sformatf("vertex_count %0d, expected %0d", vertex_count_o,
                           want.vertex_count));
        if (edge_count_o !== want.edge_count)
          report($sformatf("edge_count %0d, expected %0d", edge_count_o, want.edge_count));
        if (status_o !== want.status)
          report($sformatf("status %0d, expected %s", status_o, want.status.name()));
        if (last_o !== want.last)
          report($sformatf("last %b, expected %b", last_o, want.last));
      end
    end
  end

  initial begin
    stim_row_t       row;
    op_e             op;
    logic [IdxW-1:0] idx;
    int unsigned     n;
    int unsigned     add_pct;
    n = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_command(row.op, row.idx, row.u, row.v, 1'b0);
      if (row.typed) begin
        void'(awaited_answers.pop_back());
        awaited_answers.push_back(answer_t'{neighbor: '0, vertex_count: row.vc,
                                            edge_count: row.ec, status: row.st,
                                            last: 1'b1});
      end
    end
    drain_results();

    // random mix, adds weighted up later so the table fills and overflows
    while (n < 91) begin
      add_pct = (n >= 55) ? 90 : 60;
      idx     = '0;
      if ($urandom_range(99) < add_pct) begin
        op = OP_ADD;
      end else begin
        case ($urandom_range(2))
          0:       op = OP_DEL;
          1:       op = OP_NBR;
          default: op = OP_CNT;
        endcase
      end
      if (op == OP_DEL) begin
        if (slots_used > 0 && $urandom_range(99) < 75) begin
          idx = IdxW'($urandom_range(slots_used - 1));
        end else begin
          idx = IdxW'($urandom_range(63));
        end
      end else if ($urandom_range(99) < 20) begin
        idx = IdxW'($urandom_range(63));
      end
      send_command(op, idx, pick_vertex(), pick_vertex(), n >= 30 && n < 60);
      n++;
      if (n == 50) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
